// File: hdl/hsplit_pkg.sv
// Shared types, constants and codes of the polygon horizontal split unit.
package hsplit_pkg;

  localparam int COORD_W = 24;
  localparam int DIV_W = COORD_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int IN_DATA_W = 2 * COORD_W;
  localparam int OUT_FIELDS_W = 4 * COORD_W + 4;
  localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_DATA_W - OUT_FIELDS_W;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [1:0] CROSSINGS_NEEDED = 2'd2;
  localparam logic [1:0] MIN_SIDE_POINTS = 2'd3;
  localparam logic [0:0] REG_CUT_LEVEL = 1'b0;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_CROSSING = 2'd1,
    KIND_STATUS = 2'd2
  } item_kind_e;

  typedef enum logic [1:0] {
    SPLIT_CLEAN = 2'd0,
    SPLIT_BAD_COUNT = 2'd1,
    SPLIT_SHORT_SIDE = 2'd2
  } split_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_DIV,
    ST_CROSS,
    ST_VERT,
    ST_STAT
  } state_e;

  typedef struct packed {
    logic start;
    logic signed [DIV_W-1:0] a;
    logic signed [DIV_W-1:0] b;
    logic signed [DIV_W-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic done;
    logic signed [DIV_W-1:0] q;
  } md_rsp_t;

endpackage

// File: hdl/hsplit_muldiv.sv
// Bit-serial unit that computes trunc(a*b/d) for |b| not above |d|, one bit of a per cycle.
module hsplit_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hsplit_pkg::md_req_t req_i,
  output hsplit_pkg::md_rsp_t rsp_o
);
  import hsplit_pkg::*;

  logic                 busy_q, done_q, neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     ma_q, mb_q, md_q, r_q, q_q;
  logic signed [DIV_W-1:0] res_q;

  logic [DIV_W:0]   r2, r2s, r3, rn;
  logic             c1, c2;
  logic [DIV_W-1:0] qn;

  always_comb begin
    r2  = {r_q, 1'b0};
    c1  = (r2 >= {1'b0, md_q});
    r2s = c1 ? (r2 - {1'b0, md_q}) : r2;
    r3  = r2s + (ma_q[DIV_W-1] ? {1'b0, mb_q} : '0);
    c2  = (r3 >= {1'b0, md_q});
    rn  = c2 ? (r3 - {1'b0, md_q}) : r3;
    qn  = {q_q[DIV_W-2:0], 1'b0} + DIV_W'(c1) + DIV_W'(c2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ma_q  <= req_i.a[DIV_W-1] ? DIV_W'(-req_i.a) : DIV_W'(req_i.a);
      mb_q  <= req_i.b[DIV_W-1] ? DIV_W'(-req_i.b) : DIV_W'(req_i.b);
      md_q  <= req_i.d[DIV_W-1] ? DIV_W'(-req_i.d) : DIV_W'(req_i.d);
      neg_q <= req_i.a[DIV_W-1] ^ req_i.b[DIV_W-1] ^ req_i.d[DIV_W-1];
      r_q   <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      ma_q <= {ma_q[DIV_W-2:0], 1'b0};
      r_q  <= rn[DIV_W-1:0];
      q_q  <= qn;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        res_q <= neg_q ? -$signed(qn) : $signed(qn);
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = res_q;

endmodule

// File: hdl/polygon_horizontal_split_unit.sv
// Top level of the polygon horizontal split unit: sequencer, loop state, output register, APB.
//
//  channel   | dir | payload
//  s_axis    | in  | tdata: vertex_x, vertex_y; tlast: final_vertex
//  m_axis    | out | tdata: point, flags, status, cut ends; tuser: item_kind; tlast: last_of_run
//  apb       | in  | cut_level at byte address 0
//
// A vertex passes the edge and vertex states, plus a divide and a crossing state for each
// straddling edge, whose crossing the bit-serial multiply-divide unit resolves one bit of the
// numerator per cycle. A final vertex adds the closing edge and the status.
// Reset clears the loop state and sets cut_level to zero.
// A stalled output holds the sequencer at its next result; input is taken only when idle.
module polygon_horizontal_split_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // vertex_x, vertex_y
  input  logic [hsplit_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // point_x, point_y, to_upper, to_lower, split_status, cut_left_x, cut_right_x, zero pad
  output logic [hsplit_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // item_kind
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hsplit_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [hsplit_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hsplit_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready
);
  import hsplit_pkg::*;

  typedef struct packed {
    item_kind_e                kind;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      up;
    logic                      lo;
    split_status_e             status;
    logic signed [COORD_W-1:0] cl;
    logic signed [COORD_W-1:0] cr;
    logic                      last;
  } out_item_t;

  state_e state_q, state_d;

  logic signed [COORD_W-1:0] cut_q;
  logic signed [COORD_W-1:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q, first_x_q, first_y_q;
  logic signed [COORD_W-1:0] ca_q, cb_q;
  logic                      fin_q, leg_q, had_first_q, have_first_q;
  logic [1:0]                cc_q, uc_q, lc_q;
  logic                      m_valid_q;
  out_item_t                 out_q, out_d;

  logic                      accept, out_free, emit, straddle;
  logic signed [COORD_W-1:0] ax, ay, bx, by, cx;
  logic                      vup, vlo;
  logic signed [DIV_W:0]     cx_sum;
  logic                      md_start;
  logic signed [DIV_W-1:0]   md_a, md_b, md_d;
  md_req_t                   req;
  md_rsp_t                   rsp;
  split_status_e             stat;

  function automatic logic [1:0] sat_inc(input logic [1:0] c, input logic en);
    sat_inc = (en && c != 2'd3) ? c + 2'd1 : c;
  endfunction

  hsplit_muldiv u_muldiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  assign pready   = 1'b1;
  assign prdata   = {{(APB_DATA_W - COORD_W){cut_q[COORD_W-1]}}, cut_q};
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign req      = {md_start, md_a, md_b, md_d};

  always_comb begin
    ax = leg_q ? cur_x_q : prev_x_q;
    ay = leg_q ? cur_y_q : prev_y_q;
    bx = leg_q ? first_x_q : cur_x_q;
    by = leg_q ? first_y_q : cur_y_q;
    straddle = (ay <= cut_q) != (by <= cut_q);
    md_a = {bx[COORD_W-1], bx} - {ax[COORD_W-1], ax};
    md_b = {cut_q[COORD_W-1], cut_q} - {ay[COORD_W-1], ay};
    md_d = {by[COORD_W-1], by} - {ay[COORD_W-1], ay};
    cx_sum = {{2{ax[COORD_W-1]}}, ax} + {rsp.q[DIV_W-1], rsp.q};
    cx = cx_sum[COORD_W-1:0];
    vup = (cur_y_q <= cut_q);
    vlo = (cur_y_q >= cut_q);
    if (cc_q != CROSSINGS_NEEDED) begin
      stat = SPLIT_BAD_COUNT;
    end else if (uc_q < MIN_SIDE_POINTS || lc_q < MIN_SIDE_POINTS) begin
      stat = SPLIT_SHORT_SIDE;
    end else begin
      stat = SPLIT_CLEAN;
    end
  end

  always_comb begin
    state_d = state_q;
    s_axis_tready = 1'b0;
    emit = 1'b0;
    md_start = 1'b0;
    out_d = '0;
    out_d.kind = KIND_VERTEX;
    out_d.status = SPLIT_CLEAN;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_EDGE;
        end
      end
      ST_EDGE: begin
        if (straddle && (leg_q || had_first_q)) begin
          md_start = 1'b1;
          state_d = ST_DIV;
        end else begin
          state_d = leg_q ? ST_STAT : ST_VERT;
        end
      end
      ST_DIV: begin
        if (rsp.done) begin
          state_d = ST_CROSS;
        end
      end
      ST_CROSS: begin
        out_d.kind = KIND_CROSSING;
        out_d.px = cx;
        out_d.py = cut_q;
        out_d.up = 1'b1;
        out_d.lo = 1'b1;
        if (out_free) begin
          emit = 1'b1;
          state_d = leg_q ? ST_STAT : ST_VERT;
        end
      end
      ST_VERT: begin
        out_d.kind = KIND_VERTEX;
        out_d.px = cur_x_q;
        out_d.py = cur_y_q;
        out_d.up = vup;
        out_d.lo = vlo;
        out_d.last = !fin_q;
        if (out_free) begin
          emit = 1'b1;
          state_d = fin_q ? ST_EDGE : ST_IDLE;
        end
      end
      ST_STAT: begin
        out_d.kind = KIND_STATUS;
        out_d.status = stat;
        out_d.last = 1'b1;
        if (stat == SPLIT_CLEAN) begin
          out_d.cl = (ca_q <= cb_q) ? ca_q : cb_q;
          out_d.cr = (ca_q <= cb_q) ? cb_q : ca_q;
        end
        if (out_free) begin
          emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q        <= '0;
      have_first_q <= 1'b0;
      had_first_q  <= 1'b0;
      leg_q        <= 1'b0;
      cc_q         <= '0;
      uc_q         <= '0;
      lc_q         <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_CUT_LEVEL) begin
        cut_q <= pwdata[COORD_W-1:0];
      end
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (accept) begin
        had_first_q  <= have_first_q;
        have_first_q <= 1'b1;
        leg_q        <= 1'b0;
      end
      if (emit) begin
        case (state_q)
          ST_CROSS: begin
            cc_q <= sat_inc(cc_q, 1'b1);
            uc_q <= sat_inc(uc_q, 1'b1);
            lc_q <= sat_inc(lc_q, 1'b1);
          end
          ST_VERT: begin
            uc_q  <= sat_inc(uc_q, vup);
            lc_q  <= sat_inc(lc_q, vlo);
            leg_q <= 1'b1;
          end
          ST_STAT: begin
            have_first_q <= 1'b0;
            cc_q <= '0;
            uc_q <= '0;
            lc_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_x_q <= s_axis_tdata[COORD_W-1:0];
      cur_y_q <= s_axis_tdata[2*COORD_W-1:COORD_W];
      fin_q   <= s_axis_tlast;
      if (!have_first_q) begin
        first_x_q <= s_axis_tdata[COORD_W-1:0];
        first_y_q <= s_axis_tdata[2*COORD_W-1:COORD_W];
      end
    end
    if (emit) begin
      out_q <= out_d;
      if (state_q == ST_CROSS) begin
        if (cc_q == 2'd0) begin
          ca_q <= cx;
        end else if (cc_q == 2'd1) begin
          cb_q <= cx;
        end
      end
      if (state_q == ST_VERT) begin
        prev_x_q <= cur_x_q;
        prev_y_q <= cur_y_q;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q.cr, out_q.cl, out_q.status,
                          out_q.lo, out_q.up, out_q.py, out_q.px};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

endmodule
